// ===== sv/mwak_pkg.sv =====
// package: shared types and constants of the min window all kinds block
`timescale 1ns / 1ps

package mwak_pkg;

    localparam int KIND_W    = 8;
    localparam int NK_W      = 9;
    localparam int POS_OUT_W = 13;

    typedef struct packed {
        logic [KIND_W-1:0] kind_value;
        logic              is_last;
    } mwak_in_t;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] best_start;
        logic [POS_OUT_W-1:0] best_end;
    } mwak_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_INC,
        S_LOOP,
        S_LK,
        S_DEC,
        S_FINISH
    } mwak_state_t;

endpackage

// ===== sv/mwak_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module mwak_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/min_window_all_kinds.sv =====
// top level: shortest window covering every kind, two-pointer sequencer over two rams
`timescale 1ns / 1ps

// min_window_all_kinds takes a sequence of kind values, one request each, and on the
// request marked is_last returns the earliest shortest window (1-based start and end)
// that holds every kind 1..num_kinds, with found low and zero positions if none did.
// kinds of 0 or above num_kinds take a position but never count; num_kinds of 0 acts
// as 1 and values above MAX_KINDS saturate. once MAX_ITEMS elements are held, further
// elements are dropped but is_last still gives the result. after the result, or after
// any write of num_kinds, the sequence state clears through its per-kind valid bits.
// timing: the block takes one request at a time and stalls its input while working.
// a request runs through accept, store write and counter read-modify-write, the
// counter part left out when its kind is not counted, then the final window check,
// which a request that meets a full store skips, then for each element that leaves
// the window on the left a check, a store read and a counter read-modify-write, the
// counter part left out when the leaving kind is not counted, and for an is_last
// request the result load. the single read ports of counter ram and store set the steps.
// a finished result sits in an output register, so the next request is taken while it
// waits; a second result waits until the first one has been taken.

module min_window_all_kinds
    import mwak_pkg::*;
#(
    parameter int MAX_ITEMS = 4096,
    parameter int MAX_KINDS = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [NK_W-1:0] cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  mwak_in_t        in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output mwak_out_t       out_data
);

    // position, address and counter widths
    localparam int PW     = $clog2(MAX_ITEMS + 2);
    localparam int SAW    = $clog2(MAX_ITEMS);
    localparam int CW     = $clog2(MAX_ITEMS + 1);
    // only kinds 1..255 can ever be counted
    localparam int CDEPTH = (MAX_KINDS < 255) ? MAX_KINDS : 255;
    localparam int CKW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

    mwak_state_t state_reg, state_next;

    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              last_reg, last_next;
    logic [KIND_W-1:0] lk_reg, lk_next;
    logic [PW-1:0]     right_reg, right_next;
    logic [PW-1:0]     left_reg, left_next;
    logic [PW-1:0]     best_len_reg, best_len_next;
    logic [PW-1:0]     best_left_reg, best_left_next;
    logic [PW-1:0]     best_right_reg, best_right_next;
    logic [NK_W-1:0]   distinct_reg, distinct_next;
    logic [NK_W-1:0]   num_kinds_reg, num_kinds_next;
    logic [CDEPTH-1:0] cnt_valid_reg, cnt_valid_next;
    logic              out_valid_reg, out_valid_next;
    mwak_out_t         out_data_reg, out_data_next;

    // ram ports
    logic              st_we, st_re;
    logic [SAW-1:0]    st_waddr, st_raddr;
    logic [KIND_W-1:0] st_rdata;
    logic              cnt_we, cnt_re;
    logic [CKW-1:0]    cnt_waddr, cnt_raddr;
    logic [CW-1:0]     cnt_wdata, cnt_rdata;

    logic [NK_W-1:0]   m_eff;
    logic [CKW-1:0]    cur_cidx;
    logic [CW-1:0]     cnt_cur;
    logic [PW-1:0]     win_len;
    logic              accept;
    logic              full;
    logic              loop_go;
    logic              out_busy;

    // counted kind test against the effective kind count
    function automatic logic counted(input logic [KIND_W-1:0] k, input logic [NK_W-1:0] m);
        counted = (k != '0) && (NK_W'(k) <= m);
    endfunction

    // counter index of a kind: kind - 1
    function automatic logic [CKW-1:0] kidx(input logic [KIND_W-1:0] k);
        logic [KIND_W:0] km1;
        km1  = {1'b0, k} - {{KIND_W{1'b0}}, 1'b1};
        kidx = CKW'(km1);
    endfunction

    // element store, written once per position
    mwak_ram #(
        .WIDTH (KIND_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (kind_reg),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // per-kind occurrence counts inside the window
    mwak_ram #(
        .WIDTH (CW),
        .DEPTH (CDEPTH)
    ) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // zero means one, above the table size saturates
    always_comb
    begin
        if (num_kinds_reg == '0)
        begin
            m_eff = NK_W'(1);
        end
        else if (int'(num_kinds_reg) > MAX_KINDS)
        begin
            m_eff = NK_W'(MAX_KINDS);
        end
        else
        begin
            m_eff = num_kinds_reg;
        end
    end

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign full     = right_reg >= PW'(MAX_ITEMS);
    assign loop_go  = (distinct_reg == m_eff) && (left_reg <= right_reg);
    assign win_len  = right_reg - left_reg + PW'(1);
    assign out_busy = out_valid_reg && out_stall;

    // counter being updated: the new kind, or the kind leaving on the left
    assign cur_cidx = (state_reg == S_DEC) ? kidx(lk_reg) : kidx(kind_reg);
    // an entry not written since the last clear reads as zero
    assign cnt_cur  = cnt_valid_reg[cur_cidx] ? cnt_rdata : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (full)
                begin
                    state_next = last_reg ? S_FINISH : S_IDLE;
                end
                else if (counted(kind_reg, m_eff))
                begin
                    state_next = S_INC;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            S_INC:
            begin
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (loop_go)
                begin
                    state_next = S_LK;
                end
                else
                begin
                    state_next = last_reg ? S_FINISH : S_IDLE;
                end
            end
            S_LK:
            begin
                state_next = counted(st_rdata, m_eff) ? S_DEC : S_LOOP;
            end
            S_DEC:
            begin
                state_next = S_LOOP;
            end
            S_FINISH:
            begin
                // hold while an earlier result is still waiting
                if (!out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        kind_next       = kind_reg;
        last_next       = last_reg;
        lk_next         = lk_reg;
        right_next      = right_reg;
        left_next       = left_reg;
        best_len_next   = best_len_reg;
        best_left_next  = best_left_reg;
        best_right_next = best_right_reg;
        distinct_next   = distinct_reg;
        num_kinds_next  = num_kinds_reg;
        cnt_valid_next  = cnt_valid_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        st_we     = 1'b0;
        st_re     = 1'b0;
        st_waddr  = SAW'(right_reg);
        st_raddr  = SAW'(left_reg - PW'(1));
        cnt_we    = 1'b0;
        cnt_re    = 1'b0;
        cnt_waddr = cur_cidx;
        cnt_raddr = kidx(kind_reg);
        cnt_wdata = cnt_cur + CW'(1);

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = in_data.kind_value;
                    last_next = in_data.is_last;
                end
            end
            S_ADD:
            begin
                if (!full)
                begin
                    st_we      = 1'b1;
                    right_next = right_reg + PW'(1);
                    if (counted(kind_reg, m_eff))
                    begin
                        cnt_re = 1'b1;
                    end
                end
            end
            S_INC:
            begin
                cnt_we                   = 1'b1;
                cnt_valid_next[cur_cidx] = 1'b1;
                if (cnt_cur == '0)
                begin
                    distinct_next = distinct_reg + NK_W'(1);
                end
            end
            S_LOOP:
            begin
                if (loop_go)
                begin
                    // strictly shorter only, so the earliest window wins a tie
                    if (win_len < best_len_reg)
                    begin
                        best_len_next   = win_len;
                        best_left_next  = left_reg;
                        best_right_next = right_reg;
                    end
                    st_re = 1'b1;
                end
            end
            S_LK:
            begin
                lk_next = st_rdata;
                if (counted(st_rdata, m_eff))
                begin
                    cnt_re    = 1'b1;
                    cnt_raddr = kidx(st_rdata);
                end
                else
                begin
                    left_next = left_reg + PW'(1);
                end
            end
            S_DEC:
            begin
                if (cnt_cur != '0)
                begin
                    cnt_we                   = 1'b1;
                    cnt_wdata                = cnt_cur - CW'(1);
                    cnt_valid_next[cur_cidx] = 1'b1;
                    if (cnt_cur == CW'(1))
                    begin
                        distinct_next = distinct_reg - NK_W'(1);
                    end
                end
                left_next = left_reg + PW'(1);
            end
            S_FINISH:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    if (best_right_reg != '0)
                    begin
                        out_data_next.found      = 1'b1;
                        out_data_next.best_start = POS_OUT_W'(best_left_reg);
                        out_data_next.best_end   = POS_OUT_W'(best_right_reg);
                    end
                    else
                    begin
                        out_data_next.found      = 1'b0;
                        out_data_next.best_start = '0;
                        out_data_next.best_end   = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            num_kinds_next = cfg_data;
        end

        // sequence clear after a result or a register write
        if (cfg_we || ((state_reg == S_FINISH) && !out_busy))
        begin
            distinct_next   = '0;
            left_next       = PW'(1);
            right_next      = '0;
            best_len_next   = '1;
            best_left_next  = '0;
            best_right_next = '0;
            cnt_valid_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_reg       <= 1'b0;
            right_reg      <= '0;
            left_reg       <= PW'(1);
            best_len_reg   <= '1;
            best_left_reg  <= '0;
            best_right_reg <= '0;
            distinct_reg   <= '0;
            num_kinds_reg  <= NK_W'(1);
            cnt_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_reg       <= last_next;
            right_reg      <= right_next;
            left_reg       <= left_next;
            best_len_reg   <= best_len_next;
            best_left_reg  <= best_left_next;
            best_right_reg <= best_right_next;
            distinct_reg   <= distinct_next;
            num_kinds_reg  <= num_kinds_next;
            cnt_valid_reg  <= cnt_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        lk_reg       <= lk_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    // left pointer never passes one beyond the right pointer
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= right_reg + PW'(1))
        else $error("left pointer beyond right pointer");

    // store never holds more than its depth
    a_right_bound: assert property (@(posedge clk) disable iff (!rst_n)
        right_reg <= PW'(MAX_ITEMS))
        else $error("right pointer beyond store depth");

    // distinct count never exceeds the kinds that must be covered
    a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        distinct_reg <= m_eff)
        else $error("distinct count above effective kind count");

    // a recorded window is well formed
    a_best_window: assert property (@(posedge clk) disable iff (!rst_n)
        (best_right_reg != '0) |-> ((best_left_reg != '0) && (best_left_reg <= best_right_reg)))
        else $error("recorded window is malformed");
`endif

endmodule

// ===== verif/tb_min_window_all_kinds.sv =====
// testbench: shortest window covering all kinds, random and directed sequences with scoreboard
`timescale 1ns / 1ps

module tb_min_window_all_kinds;
    import mwak_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int KIND_LIMIT  = 256;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 60;

    // stimulus side, all known from time zero
    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [NK_W-1:0] cfg_data  = '0;
    logic            in_valid  = 1'b0;
    mwak_in_t        in_data   = '0;
    logic            out_stall = 1'b0;
    logic            in_stall;
    logic            out_valid;
    mwak_out_t       out_data;

    // requests waiting to be driven, windows waiting to come back
    mwak_in_t  req_pending [$];
    mwak_out_t window_due [$];

    // shadow copy of the block's sequence state
    logic [KIND_W-1:0] seq_store [0:STORE_DEPTH-1];
    int unsigned       kind_cnt  [0:KIND_LIMIT-1];
    int unsigned       distinct_cnt;
    int unsigned       left_p;
    int unsigned       right_p;
    int unsigned       best_len;
    int unsigned       best_l;
    int unsigned       best_r;
    logic [NK_W-1:0]   kinds_reg;

    // run bookkeeping
    bit          steady_mode = 1'b0;
    int unsigned send_gap;
    int unsigned hold_gap;
    int unsigned sent_count   = 0;
    int unsigned results_seen = 0;
    int unsigned found_seen   = 0;
    int unsigned cfg_writes   = 0;
    int unsigned fail_count   = 0;
    mwak_out_t   want_res;

    // kind counts that the random phases walk through, extremes included
    int unsigned kind_plan [RAND_PHASES] = '{2, 3, 4, 1, 7, 12, 256, 5, 511, 9};

    min_window_all_kinds #(
        .MAX_ITEMS (STORE_DEPTH),
        .MAX_KINDS (KIND_LIMIT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // zero and oversized register values fold into 1..KIND_LIMIT
    function automatic int unsigned kinds_in_force();
        if (kinds_reg == 0)
            return 1;
        if (kinds_reg > KIND_LIMIT)
            return KIND_LIMIT;
        return 32'(kinds_reg);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < KIND_LIMIT; i++)
            kind_cnt[i] = 0;
        distinct_cnt = 0;
        left_p       = 1;
        right_p      = 0;
        best_len     = 32'hFFFF_FFFF;
        best_l       = 0;
        best_r       = 0;
    endfunction

    // two-pointer step for one accepted request, queues the window on is_last
    function automatic void window_advance(mwak_in_t req);
        int unsigned m;
        int unsigned kv;
        int unsigned lk;
        mwak_out_t   res;
        m  = kinds_in_force();
        kv = 32'(req.kind_value);
        // a full store drops the element but still honors is_last
        if (right_p < STORE_DEPTH)
        begin
            seq_store[right_p] = req.kind_value;
            right_p++;
            if (kv >= 1 && kv <= m)
            begin
                if (kind_cnt[kv-1] == 0)
                    distinct_cnt++;
                kind_cnt[kv-1]++;
            end
            // shrink from the left while covered, strictly shorter wins so earliest ties stay
            while (distinct_cnt == m && left_p <= right_p)
            begin
                if (right_p - left_p + 1 < best_len)
                begin
                    best_len = right_p - left_p + 1;
                    best_l   = left_p;
                    best_r   = right_p;
                end
                lk = 32'(seq_store[(left_p - 1) % STORE_DEPTH]);
                if (lk >= 1 && lk <= m && kind_cnt[lk-1] > 0)
                begin
                    kind_cnt[lk-1]--;
                    if (kind_cnt[lk-1] == 0)
                        distinct_cnt--;
                end
                left_p++;
            end
        end
        if (req.is_last)
        begin
            res.found      = (best_r != 0);
            res.best_start = res.found ? POS_OUT_W'(best_l) : '0;
            res.best_end   = res.found ? POS_OUT_W'(best_r) : '0;
            window_due.push_back(res);
            clear_window();
        end
    endfunction

    // mostly short gaps, now and then a long one, none in steady mode
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic push_item(input int unsigned kind, input bit last);
        mwak_in_t req;
        req.kind_value = KIND_W'(kind);
        req.is_last    = last;
        req_pending.push_back(req);
    endtask

    // random sequence: mostly in-range kinds, some zeros and arbitrary bytes
    task automatic queue_sequence(input int unsigned len, input bit close);
        int unsigned m;
        int unsigned r;
        int unsigned k;
        m = kinds_in_force();
        for (int unsigned i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (m >= 255 || r >= 85)
                k = $urandom_range(0, 255);
            else if (r >= 78)
                k = 0;
            else
                k = $urandom_range(1, m);
            push_item(k, close && (i == len - 1));
        end
    endtask

    // wait until every request is taken, every window is back and the block is idle
    task automatic settle_block();
        @(negedge clk);
        while (req_pending.size() != 0 || in_valid || in_stall || window_due.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // register writes only with the block idle; a write also drops any open sequence
    task automatic write_kinds(input logic [NK_W-1:0] v);
        settle_block();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        kinds_reg = v;
        clear_window();
        cfg_writes++;
    endtask

    // request driver: predicts on every accepted request, then refills the slot
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                window_advance(in_data);
                sent_count++;
            end
            // slot is free when idle or just accepted; a held payload stays put
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (req_pending.size() > 0)
                begin
                    in_data  <= req_pending.pop_front();
                    in_valid <= 1'b1;
                    send_gap  = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor: random back-pressure and field-by-field compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_gap   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (window_due.size() == 0)
                begin
                    $error("unexpected result: found=%0d best_start=%0d best_end=%0d",
                           out_data.found, out_data.best_start, out_data.best_end);
                    fail_count++;
                end
                else
                begin
                    want_res = window_due.pop_front();
                    results_seen++;
                    if (want_res.found)
                        found_seen++;
                    if (out_data.found !== want_res.found)
                    begin
                        $error("found: expected %0d, got %0d", want_res.found, out_data.found);
                        fail_count++;
                    end
                    if (out_data.best_start !== want_res.best_start)
                    begin
                        $error("best_start: expected %0d, got %0d",
                               want_res.best_start, out_data.best_start);
                        fail_count++;
                    end
                    if (out_data.best_end !== want_res.best_end)
                    begin
                        $error("best_end: expected %0d, got %0d",
                               want_res.best_end, out_data.best_end);
                        fail_count++;
                    end
                end
            end
            if (hold_gap > 0)
            begin
                hold_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                hold_gap   = pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int unsigned m;
        int unsigned len;
        int unsigned budget;
        int unsigned perm [255];
        int unsigned j;
        int unsigned t;

        // shadow state starts at the reset values
        kinds_reg = 1;
        clear_window();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset value of one kind, out-of-range kinds take positions
        push_item(0, 0);
        push_item(255, 0);
        push_item(1, 1);
        // equal lengths, earliest window must win
        push_item(1, 0);
        push_item(1, 1);

        write_kinds(3);
        // several windows of length three, the first one is reported
        push_item(2, 0);
        push_item(0, 0);
        push_item(1, 0);
        push_item(3, 0);
        push_item(2, 0);
        push_item(1, 0);
        push_item(3, 1);
        // kind three missing, nothing found
        push_item(1, 0);
        push_item(2, 0);
        push_item(1, 1);
        // single-request sequence
        push_item(3, 1);

        // zero kinds behaves as one
        write_kinds(0);
        push_item(200, 0);
        push_item(1, 1);
        // open sequence abandoned by a register write
        push_item(1, 0);
        write_kinds(2);
        push_item(2, 0);
        push_item(1, 1);

        // oversized count saturates and can never be covered
        write_kinds(511);
        push_item(1, 0);
        push_item(2, 0);
        push_item(255, 1);

        // random phases, one kind count each
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_kinds(NK_W'(kind_plan[p]));
            steady_mode = (p % 4 == 3);
            budget = 0;
            while (budget < PHASE_ITEMS)
            begin
                m   = kinds_in_force();
                len = $urandom_range(1, (m > 16) ? 48 : 3 * m + 6);
                if ($urandom_range(0, 9) == 0)
                begin
                    // broken sequence: no is_last, cleared by rewriting the register
                    queue_sequence(len, 1'b0);
                    write_kinds(NK_W'(kind_plan[p]));
                end
                else
                    queue_sequence(len, 1'b1);
                budget += len;
                // now and then the sender holds off until every pending window is back
                if ($urandom_range(0, 5) == 0)
                    settle_block();
            end
        end

        // largest coverable count: a shuffled full set with noise mixed in
        steady_mode = 1'b0;
        write_kinds(255);
        for (int i = 0; i < 255; i++)
            perm[i] = i + 1;
        for (int i = 254; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        repeat ($urandom_range(0, 10)) push_item($urandom_range(0, 255), 0);
        for (int i = 0; i < 255; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_item($urandom_range(0, 255), 0);
            push_item(perm[i], 0);
        end
        repeat ($urandom_range(0, 10)) push_item($urandom_range(0, 255), 0);
        push_item($urandom_range(0, 255), 1);
        settle_block();

        $display("covered %0d requests, %0d windows checked (%0d found), %0d register writes",
                 sent_count, results_seen, found_seen, cfg_writes);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // guard against a hung handshake
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
